/* sv/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/s20_pkg.sv */
// ----------------------------------------------------------------------------
// Salsa20 package
// Shared types, constants and the quarter-round function.
// ----------------------------------------------------------------------------
package s20_pkg;

    localparam logic [31:0] C_SIGMA0 = 32'h61707865;
    localparam logic [31:0] C_SIGMA1 = 32'h3320646e;
    localparam logic [31:0] C_SIGMA2 = 32'h79622d32;
    localparam logic [31:0] C_TAU1   = 32'h3120646e;
    localparam logic [31:0] C_TAU2   = 32'h79622d36;
    localparam logic [31:0] C_SIGMA3 = 32'h6b206574;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW_A   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW_B   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH_A  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH_B  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_COUNT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_MODE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_KEY    = 3'd7;

    localparam logic [1:0] MODE_R8  = 2'd0;
    localparam logic [1:0] MODE_R12 = 2'd1;

    typedef logic [15:0][31:0] t_block;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic [63:0] counter;
    } t_core_req;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [127:0] quarter(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d);
        logic [31:0] b2, c2, d2, a2;
        b2 = b ^ rotl(a + d, 7);
        c2 = c ^ rotl(b2 + a, 9);
        d2 = d ^ rotl(c2 + b2, 13);
        a2 = a ^ rotl(d2 + c2, 18);
        quarter = {a2, b2, c2, d2};
    endfunction

endpackage

/* sv/s20_stream_if.sv */
// ----------------------------------------------------------------------------
// Salsa20 stream interface
// Valid/ready channel carrying a data word, its byte count and a last mark.
// ----------------------------------------------------------------------------
interface s20_stream_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        end_of_message;

    modport source (output valid, output data_word, output byte_count,
                    output end_of_message, input ready);
    modport sink (input valid, input data_word, input byte_count,
                  input end_of_message, output ready);
endinterface

/* sv/s20_core.sv */
// ----------------------------------------------------------------------------
// Salsa20 block core
// Builds the input block and runs column and row rounds, four quarter-rounds
// per half round and one half round per cycle, then adds the feed-forward.
// ----------------------------------------------------------------------------
module s20_core
    import s20_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_core_req   i_req,
    input  logic [63:0] i_key_low_a,
    input  logic [63:0] i_key_low_b,
    input  logic [63:0] i_key_high_a,
    input  logic [63:0] i_key_high_b,
    input  logic [63:0] i_nonce,
    input  logic [1:0]  i_round_mode,
    input  logic        i_long_key,
    output logic        o_done,
    output t_block      o_block
);

    t_block      r_in, r_x, n_in;
    logic [4:0]  r_step;
    logic [4:0]  w_last_step;
    logic        r_busy;
    logic        r_done;
    t_block      w_half;
    logic [63:0] w_k2, w_k3;

    always_comb begin
        w_k2 = i_long_key ? i_key_high_a : i_key_low_a;
        w_k3 = i_long_key ? i_key_high_b : i_key_low_b;
        n_in[0]  = C_SIGMA0;
        n_in[1]  = i_key_low_a[31:0];
        n_in[2]  = i_key_low_a[63:32];
        n_in[3]  = i_key_low_b[31:0];
        n_in[4]  = i_key_low_b[63:32];
        n_in[5]  = i_long_key ? C_SIGMA1 : C_TAU1;
        n_in[6]  = i_nonce[31:0];
        n_in[7]  = i_nonce[63:32];
        n_in[8]  = i_req.counter[31:0];
        n_in[9]  = i_req.counter[63:32];
        n_in[10] = i_long_key ? C_SIGMA2 : C_TAU2;
        n_in[11] = w_k2[31:0];
        n_in[12] = w_k2[63:32];
        n_in[13] = w_k3[31:0];
        n_in[14] = w_k3[63:32];
        n_in[15] = C_SIGMA3;
        unique case (i_round_mode)
            MODE_R8:  w_last_step = 5'd7;
            MODE_R12: w_last_step = 5'd11;
            default:  w_last_step = 5'd19;
        endcase
    end

    always_comb begin
        w_half = r_x;
        if (!r_step[0]) begin
            {w_half[0], w_half[4], w_half[8], w_half[12]} =
                quarter(r_x[0], r_x[4], r_x[8], r_x[12]);
            {w_half[5], w_half[9], w_half[13], w_half[1]} =
                quarter(r_x[5], r_x[9], r_x[13], r_x[1]);
            {w_half[10], w_half[14], w_half[2], w_half[6]} =
                quarter(r_x[10], r_x[14], r_x[2], r_x[6]);
            {w_half[15], w_half[3], w_half[7], w_half[11]} =
                quarter(r_x[15], r_x[3], r_x[7], r_x[11]);
        end else begin
            {w_half[0], w_half[1], w_half[2], w_half[3]} =
                quarter(r_x[0], r_x[1], r_x[2], r_x[3]);
            {w_half[5], w_half[6], w_half[7], w_half[4]} =
                quarter(r_x[5], r_x[6], r_x[7], r_x[4]);
            {w_half[10], w_half[11], w_half[8], w_half[9]} =
                quarter(r_x[10], r_x[11], r_x[8], r_x[9]);
            {w_half[15], w_half[12], w_half[13], w_half[14]} =
                quarter(r_x[15], r_x[12], r_x[13], r_x[14]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == w_last_step) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_in <= n_in;
            r_x  <= n_in;
        end else if (r_busy) begin
            r_x <= w_half;
        end
    end

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            o_block[i] = r_x[i] + r_in[i];
        end
    end

    assign o_done = r_done;

`include "assert_macros.svh"

    `ASSERT_NEXT(a_done_after_busy, i_clk, i_rst_n, r_done, !r_busy, "core done while busy")
    `ASSERT_IMPL(a_no_start_busy, i_clk, i_rst_n, i_req.start, !r_busy, "core restarted while busy")
    `ASSERT_IMPL(a_step_range, i_clk, i_rst_n, r_busy, r_step <= 5'd19, "round step out of range")

endmodule

/* sv/salsa20_stream_cipher.sv */
// ----------------------------------------------------------------------------
// Salsa20 stream cipher
// Keystream XOR engine over 64-bit data words.
// ----------------------------------------------------------------------------
// Usage: data words enter on the s_in sink channel and leave on the m_out
// source channel, one result transaction per input transaction. Registers must
// be written over the configuration port only while the block is idle, which
// the block itself does not enforce; a write of the start counter reloads the
// block counter and drops any held keystream block. A word that needs a fresh
// block waits for the core: 8, 12 or 20 half rounds, one per cycle on four
// quarter-round units; then the core's done flag is registered, the new block
// is loaded into the keystream registers and the result is registered in the
// round state before it is offered in the output state. A word served from
// the held block has its result registered in the round state and offered in
// the output state. Either way the input is ready again in the cycle after
// the result leaves. The input is not ready while a word is at work or its
// result waits; a stalled receiver holds the result and blocks further input.
// Reset clears the control state, loads the register reset values and leaves
// no keystream block held. The keystream is kept in flip-flops.
// ----------------------------------------------------------------------------
module salsa20_stream_cipher
    import s20_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    s20_stream_if.sink            s_in,
    s20_stream_if.source          m_out
);

    logic [63:0] r_key_la, r_key_lb, r_key_ha, r_key_hb, r_nonce, r_counter;
    logic [1:0]  r_mode;
    logic        r_long;
    logic [3:0]  r_pos, n_pos;
    t_state      r_state, n_state;
    logic [63:0] r_data;
    logic [3:0]  r_count;
    logic        r_last;
    t_block      r_ks;
    logic [63:0] r_out_word;
    t_core_req   w_req;
    logic        w_done;
    t_block      w_block;
    logic        w_in_acc, w_out_acc;
    logic [63:0] w_ks, w_mask;
    logic [3:0]  w_valid;

    s20_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (w_req),
        .i_key_low_a  (r_key_la),
        .i_key_low_b  (r_key_lb),
        .i_key_high_a (r_key_ha),
        .i_key_high_b (r_key_hb),
        .i_nonce      (r_nonce),
        .i_round_mode (r_mode),
        .i_long_key   (r_long),
        .o_done       (w_done),
        .o_block      (w_block)
    );

    assign w_in_acc  = s_in.valid && s_in.ready;
    assign w_out_acc = m_out.valid && m_out.ready;
    assign s_in.ready = (r_state == ST_IDLE);
    assign m_out.valid = (r_state == ST_OUT);
    assign m_out.data_word = r_out_word;
    assign m_out.byte_count = r_count;
    assign m_out.end_of_message = r_last;

    assign w_req.start   = w_in_acc && r_pos[3];
    assign w_req.counter = r_counter;

    always_comb begin
        w_valid = (r_count > 4'd8) ? 4'd8 : r_count;
        w_ks = {r_ks[{r_pos[2:0], 1'b1}], r_ks[{r_pos[2:0], 1'b0}]};
        for (int i = 0; i < 8; i++) begin
            w_mask[8*i +: 8] = (4'(i) < w_valid) ? 8'hff : 8'h00;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) n_state = ST_ROUND;
            end
            ST_ROUND: begin
                if (!r_pos[3]) begin
                    n_state = ST_OUT;
                    n_pos   = r_last ? 4'd8 : r_pos + 4'd1;
                end
            end
            ST_OUT: begin
                if (w_out_acc) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pos     <= 4'd8;
            r_key_la  <= '0;
            r_key_lb  <= '0;
            r_key_ha  <= '0;
            r_key_hb  <= '0;
            r_nonce   <= '0;
            r_counter <= '0;
            r_mode    <= 2'd2;
            r_long    <= 1'b1;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            if (w_done) begin
                r_pos     <= 4'd0;
                r_counter <= r_counter + 64'd1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_KEY_LOW_A:   r_key_la <= i_cfg_data;
                    REG_KEY_LOW_B:   r_key_lb <= i_cfg_data;
                    REG_KEY_HIGH_A:  r_key_ha <= i_cfg_data;
                    REG_KEY_HIGH_B:  r_key_hb <= i_cfg_data;
                    REG_NONCE:       r_nonce  <= i_cfg_data;
                    REG_START_COUNT: begin
                        r_counter <= i_cfg_data;
                        r_pos     <= 4'd8;
                    end
                    REG_ROUND_MODE:  r_mode <= i_cfg_data[1:0];
                    REG_LONG_KEY:    r_long <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_data  <= s_in.data_word;
            r_count <= s_in.byte_count;
            r_last  <= s_in.end_of_message;
        end
        if (w_done) r_ks <= w_block;
        if (r_state == ST_ROUND && !r_pos[3]) r_out_word <= r_data ^ (w_ks & w_mask);
    end

`include "assert_macros.svh"

    `ASSERT_IMPL(a_out_holds, i_clk, i_rst_n, m_out.valid && !m_out.ready,
                 ##1 m_out.valid, "result dropped under stall")
    `ASSERT_IMPL(a_done_in_round, i_clk, i_rst_n, w_done, r_state == ST_ROUND,
                 "block finished outside round state")
    `ASSERT_IMPL(a_excl, i_clk, i_rst_n, 1'b1, !(s_in.ready && m_out.valid),
                 "input ready while result pending")

endmodule

/* test/salsa20_stream_cipher_checker.sv */
// ----------------------------------------------------------------------------
// Salsa20 stream cipher checker
// Watches the register port and both channels, computes the expected
// keystream XOR for each input transaction and compares the output
// transactions against it in order.
// ----------------------------------------------------------------------------
module salsa20_stream_cipher_checker
    import s20_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    s20_stream_if                 s_in,
    s20_stream_if                 m_out,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  count;
        logic        last;
    } t_cipher_out;

    logic [63:0] key_la, key_lb, key_ha, key_hb, nonce, blk_ctr;
    logic [1:0]  rounds_sel;
    logic        key_long;
    logic [31:0] ks_words [16];
    logic [3:0]  ks_pos;
    t_cipher_out cipher_q [$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending = cipher_q.size();

    function automatic logic [31:0] rol32(logic [31:0] v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    task automatic mix_quarter(ref logic [31:0] x [16], input int a, b, c, d);
        x[b] = x[b] ^ rol32(x[a] + x[d], 7);
        x[c] = x[c] ^ rol32(x[b] + x[a], 9);
        x[d] = x[d] ^ rol32(x[c] + x[b], 13);
        x[a] = x[a] ^ rol32(x[d] + x[c], 18);
    endtask

    task automatic generate_keystream();
        logic [31:0] init [16];
        logic [31:0] x [16];
        logic [63:0] k2, k3;
        int          dbl;
        k2 = key_long ? key_ha : key_la;
        k3 = key_long ? key_hb : key_lb;
        init[0] = C_SIGMA0;          init[1] = key_la[31:0];
        init[2] = key_la[63:32];     init[3] = key_lb[31:0];
        init[4] = key_lb[63:32];     init[5] = key_long ? C_SIGMA1 : C_TAU1;
        init[6] = nonce[31:0];       init[7] = nonce[63:32];
        init[8] = blk_ctr[31:0];     init[9] = blk_ctr[63:32];
        init[10] = key_long ? C_SIGMA2 : C_TAU2;
        init[11] = k2[31:0];         init[12] = k2[63:32];
        init[13] = k3[31:0];         init[14] = k3[63:32];
        init[15] = C_SIGMA3;
        dbl = (rounds_sel == MODE_R8) ? 4 : (rounds_sel == MODE_R12) ? 6 : 10;
        x = init;
        for (int i = 0; i < dbl; i++) begin
            mix_quarter(x, 0, 4, 8, 12);
            mix_quarter(x, 5, 9, 13, 1);
            mix_quarter(x, 10, 14, 2, 6);
            mix_quarter(x, 15, 3, 7, 11);
            mix_quarter(x, 0, 1, 2, 3);
            mix_quarter(x, 5, 6, 7, 4);
            mix_quarter(x, 10, 11, 8, 9);
            mix_quarter(x, 15, 12, 13, 14);
        end
        for (int i = 0; i < 16; i++) ks_words[i] = x[i] + init[i];
        blk_ctr = blk_ctr + 64'd1;
        ks_pos = 4'd0;
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
        fails++;
    endtask

    always @(posedge i_clk) begin
        t_cipher_out exp_out;
        logic [63:0] ks, mask;
        int          nbytes;
        if (!i_rst_n) begin
            key_la = '0; key_lb = '0; key_ha = '0; key_hb = '0; nonce = '0;
            blk_ctr = '0; rounds_sel = 2'd2; key_long = 1'b1; ks_pos = 4'd8;
            cipher_q.delete();
            fails = fails;
        end else begin
            if (m_out.valid && m_out.ready) begin
                if (cipher_q.size() == 0) begin
                    report_mismatch("unexpected transaction", m_out.data_word, '0);
                end else begin
                    exp_out = cipher_q.pop_front();
                    if (m_out.data_word !== exp_out.word)
                        report_mismatch("result word", m_out.data_word, exp_out.word);
                    if (m_out.byte_count !== exp_out.count)
                        report_mismatch("result count", m_out.byte_count, exp_out.count);
                    if (m_out.end_of_message !== exp_out.last)
                        report_mismatch("result last", m_out.end_of_message, exp_out.last);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_KEY_LOW_A:   key_la = i_cfg_data;
                    REG_KEY_LOW_B:   key_lb = i_cfg_data;
                    REG_KEY_HIGH_A:  key_ha = i_cfg_data;
                    REG_KEY_HIGH_B:  key_hb = i_cfg_data;
                    REG_NONCE:       nonce = i_cfg_data;
                    REG_START_COUNT: begin
                        blk_ctr = i_cfg_data;
                        ks_pos = 4'd8;
                    end
                    REG_ROUND_MODE:  rounds_sel = i_cfg_data[1:0];
                    REG_LONG_KEY:    key_long = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (s_in.valid && s_in.ready) begin
                if (ks_pos >= 4'd8) generate_keystream();
                ks = {ks_words[2 * ks_pos[2:0] + 1], ks_words[2 * ks_pos[2:0]]};
                nbytes = (s_in.byte_count > 4'd8) ? 8 : int'(s_in.byte_count);
                mask = (nbytes >= 8) ? '1 : ((64'd1 << (8 * nbytes)) - 64'd1);
                exp_out.word = s_in.data_word ^ (ks & mask);
                exp_out.count = s_in.byte_count;
                exp_out.last = s_in.end_of_message;
                cipher_q.push_back(exp_out);
                ks_pos = s_in.end_of_message ? 4'd8 : ks_pos + 4'd1;
            end
        end
    end

    initial fails = 0;
endmodule

/* test/salsa20_stream_cipher_test.sv */
// ----------------------------------------------------------------------------
// Salsa20 stream cipher testbench
// Drives register settings and message words with random idling and a long
// output stall; the checker compares every output transaction.
// ----------------------------------------------------------------------------
module salsa20_stream_cipher_test;
    import s20_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    int                    fail_count, pending, cycles = 0;
    bit                    calm_out = 1'b0;
    bit                    hold_out = 1'b0;
    bit                    sending = 1'b0;

    s20_stream_if s_in ();
    s20_stream_if m_out ();

    salsa20_stream_cipher uut (.i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
                               .s_in(s_in.sink), .m_out(m_out.source));

    salsa20_stream_cipher_checker chk (.i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx,
        .i_cfg_data, .s_in(s_in), .m_out(m_out), .o_fail_count(fail_count),
        .o_pending(pending));

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        s_in.valid = 1'b0;
        s_in.data_word = '0;
        s_in.byte_count = 4'd8;
        s_in.end_of_message = 1'b0;
        m_out.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_out) m_out.ready <= 1'b0;
        else m_out.ready <= calm_out || ($urandom_range(99) >= 24);
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic send_word(logic [63:0] w, logic [3:0] n, logic e, bit calm);
        while (!calm && $urandom_range(99) < 24) begin
            s_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        s_in.valid <= 1'b1;
        s_in.data_word <= w;
        s_in.byte_count <= n;
        s_in.end_of_message <= e;
        do @(posedge i_clk); while (!s_in.ready);
    endtask

    task automatic drain_and_settle();
        s_in.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic apply_setting(logic [1:0] mode, logic lk, bit extreme);
        for (int r = 0; r < 5; r++)
            write_reg(r[2:0], extreme ? ((r % 2) ? '1 : '0) : {$urandom, $urandom});
        write_reg(REG_START_COUNT, extreme ? 64'hFFFF_FFFF_FFFF_FFFE
                                           : {$urandom, $urandom});
        write_reg(REG_ROUND_MODE, {62'd0, mode});
        write_reg(REG_LONG_KEY, {63'd0, lk});
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_message(int len, bit calm);
        logic [3:0] n;
        bit         e;
        for (int k = 0; k < len; k++) begin
            e = (k == len - 1);
            n = 4'd8;
            if ($urandom_range(9) == 0) n = 4'($urandom_range(15));
            else if (e) n = 4'($urandom_range(1, 8));
            send_word({$urandom, $urandom}, n, e, calm);
        end
    endtask

    initial begin
        int sent;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset keys first, then extremes across the byte counts.
        send_word('0, 4'd8, 1'b0, 1'b0);
        send_word('1, 4'd8, 1'b1, 1'b0);
        drain_and_settle();
        apply_setting(2'd3, 1'b0, 1'b1);
        for (int n = 0; n < 16; n++)
            send_word(n[0] ? '1 : 64'hA5A5_5A5A_0F0F_F0F0, 4'(n), n == 15, 1'b0);
        drain_and_settle();
        apply_setting(MODE_R8, 1'b1, 1'b1);
        send_message(12, 1'b0);
        drain_and_settle();

        sent = 0;
        for (int phase = 0; sent < 1100; phase++) begin
            apply_setting(2'($urandom_range(3)), 1'($urandom), 1'b0);
            calm_out = (phase == 3);
            if (phase == 5) begin
                fork
                    begin
                        hold_out = 1'b1;
                        repeat (300) @(posedge i_clk);
                        hold_out = 1'b0;
                    end
                join_none
            end
            for (int m = 0; m < 6; m++) begin
                int len;
                len = $urandom_range(1, 24);
                send_message(len, phase == 3);
                sent += len;
            end
            drain_and_settle();
        end
        calm_out = 1'b0;

        if (fail_count == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule
